// File: src/dirt_pkg.sv
package dirt_pkg;

    localparam int ENTRIES     = 64;
    localparam int SLOT_BITS   = $clog2(ENTRIES);
    localparam int USED_BITS   = $clog2(ENTRIES + 1);
    localparam int INST_BITS   = 16;
    localparam int CNT_BITS    = INST_BITS + 1;
    localparam int WORD_BITS   = 32;
    localparam int CMD_BITS    = 2;
    localparam int STATUS_BITS = 3;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    // A read of a valid slot also answers ST_MERGED.
    typedef enum logic [STATUS_BITS-1:0] {
        ST_MERGED    = 3'd0,
        ST_APPENDED  = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_TRIMMED   = 3'd3,
        ST_SPLIT     = 3'd4,
        ST_NOT_FOUND = 3'd5,
        ST_FULL      = 3'd6
    } t_status;

    typedef struct packed {
        logic [INST_BITS-1:0]        base;
        logic [CNT_BITS-1:0]         count;
        logic [WORD_BITS-1:0]        first_index;
        logic signed [WORD_BITS-1:0] base_vertex;
        logic [WORD_BITS-1:0]        index_count;
    } t_entry;

    typedef struct packed {
        logic                 add_hit;
        logic                 rem_hit;
        logic                 merge_ok;
        logic                 single;
        logic                 top_end;
        logic                 low_end;
        logic [CNT_BITS-1:0]  sum;
        logic [INST_BITS-1:0] base_inc;
        logic [CNT_BITS-1:0]  count_dec;
        logic [INST_BITS-1:0] upper_base;
        logic [CNT_BITS-1:0]  upper_count;
        logic [CNT_BITS-1:0]  lower_count;
    } t_unit_res;

endpackage

// File: src/dirt_ifs.sv
interface dirt_cmd_if;
    logic                                  valid;
    logic                                  ready;
    logic [dirt_pkg::CMD_BITS-1:0]         cmd;
    logic [dirt_pkg::INST_BITS-1:0]        instance_index;
    logic [dirt_pkg::CNT_BITS-1:0]         run_length;
    logic [dirt_pkg::WORD_BITS-1:0]        first_index;
    logic signed [dirt_pkg::WORD_BITS-1:0] base_vertex;
    logic [dirt_pkg::WORD_BITS-1:0]        index_count;
    logic [dirt_pkg::SLOT_BITS-1:0]        slot;

    modport source (
        output valid, cmd, instance_index, run_length, first_index, base_vertex,
               index_count, slot,
        input  ready
    );
    modport sink (
        input  valid, cmd, instance_index, run_length, first_index, base_vertex,
               index_count, slot,
        output ready
    );
endinterface

interface dirt_res_if;
    logic                                  valid;
    logic                                  ready;
    logic [dirt_pkg::STATUS_BITS-1:0]      status;
    logic [dirt_pkg::SLOT_BITS-1:0]        entry_slot;
    logic [dirt_pkg::USED_BITS-1:0]        entries_used;
    logic [dirt_pkg::INST_BITS-1:0]        out_base_instance;
    logic [dirt_pkg::CNT_BITS-1:0]         out_run_length;
    logic [dirt_pkg::WORD_BITS-1:0]        out_first_index;
    logic signed [dirt_pkg::WORD_BITS-1:0] out_base_vertex;
    logic [dirt_pkg::WORD_BITS-1:0]        out_index_count;

    modport source (
        output valid, status, entry_slot, entries_used, out_base_instance,
               out_run_length, out_first_index, out_base_vertex, out_index_count,
        input  ready
    );
    modport sink (
        input  valid, status, entry_slot, entries_used, out_base_instance,
               out_run_length, out_first_index, out_base_vertex, out_index_count,
        output ready
    );
endinterface

// File: src/dirt_mem.sv
module dirt_mem (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [dirt_pkg::SLOT_BITS-1:0] i_waddr,
    input  dirt_pkg::t_entry               i_wdata,
    input  logic [dirt_pkg::SLOT_BITS-1:0] i_raddr,
    output dirt_pkg::t_entry               o_rdata
);

    dirt_pkg::t_entry r_mem [dirt_pkg::ENTRIES];
    dirt_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/dirt_unit.sv
module dirt_unit (
    input  dirt_pkg::t_entry               i_ent,
    input  logic [dirt_pkg::INST_BITS-1:0] i_idx,
    input  logic [dirt_pkg::CNT_BITS-1:0]  i_len,
    input  logic [dirt_pkg::WORD_BITS-1:0] i_fi,
    output dirt_pkg::t_unit_res            o_res
);

    localparam int EXT_BITS = dirt_pkg::CNT_BITS + 1;

    logic [EXT_BITS-1:0] run_end;
    logic [EXT_BITS-1:0] idx_ext;
    logic [EXT_BITS-1:0] idx_p1;
    logic [EXT_BITS-1:0] sum_ext;
    logic [EXT_BITS-1:0] upper_diff;

    // Run ends are compared at full width so that they never wrap.
    assign run_end    = EXT_BITS'(i_ent.base) + EXT_BITS'(i_ent.count);
    assign idx_ext    = EXT_BITS'(i_idx);
    assign idx_p1     = idx_ext + EXT_BITS'(1);
    assign sum_ext    = EXT_BITS'(i_ent.count) + EXT_BITS'(i_len);
    assign upper_diff = run_end - idx_p1;

    always_comb begin
        o_res.add_hit     = (run_end == idx_ext);
        o_res.rem_hit     = (i_ent.base <= i_idx) && (run_end > idx_ext);
        o_res.merge_ok    = (i_ent.first_index == i_fi) && !sum_ext[EXT_BITS-1];
        o_res.sum         = sum_ext[dirt_pkg::CNT_BITS-1:0];
        o_res.single      = (i_ent.count == dirt_pkg::CNT_BITS'(1));
        o_res.top_end     = (run_end == idx_p1);
        o_res.low_end     = (i_ent.base == i_idx);
        o_res.base_inc    = i_ent.base + dirt_pkg::INST_BITS'(1);
        o_res.count_dec   = i_ent.count - dirt_pkg::CNT_BITS'(1);
        o_res.upper_base  = i_idx + dirt_pkg::INST_BITS'(1);
        o_res.upper_count = upper_diff[dirt_pkg::CNT_BITS-1:0];
        o_res.lower_count = dirt_pkg::CNT_BITS'(i_idx - i_ent.base);
    end

endmodule

// File: src/draw_instance_range_table.sv
// Table of up to 64 indirect draw runs kept in a single-port-read memory and
// examined by one compare unit, one entry per clock. The block takes one
// command at a time. An add or remove scans the valid entries (newest first
// for add, oldest first for remove), one memory read per entry, and answers
// through S_ACT and S_DONE, with S_SWAP or S_SPLIT between them for a
// swap-remove or a split; a missed remove goes straight to S_DONE.
// A read of a valid slot answers through S_RDWAIT, S_RDOUT and S_DONE, a read
// of an unused slot through S_DONE alone. A command of code 3 is taken and
// dropped. The next command is taken while a result still waits in the output
// register; its own answer then waits until that result has been taken.
module draw_instance_range_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dirt_cmd_if.sink    i_cmd,
    dirt_res_if.source  o_res
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SCAN   = 8'b0000_0010,
        S_ACT    = 8'b0000_0100,
        S_SWAP   = 8'b0000_1000,
        S_SPLIT  = 8'b0001_0000,
        S_RDWAIT = 8'b0010_0000,
        S_RDOUT  = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    typedef struct packed {
        dirt_pkg::t_cmd                        cmd;
        logic [dirt_pkg::INST_BITS-1:0]        idx;
        logic [dirt_pkg::CNT_BITS-1:0]         len;
        logic [dirt_pkg::WORD_BITS-1:0]        fi;
        logic signed [dirt_pkg::WORD_BITS-1:0] bv;
        logic [dirt_pkg::WORD_BITS-1:0]        ic;
    } t_req;

    typedef struct packed {
        dirt_pkg::t_status              status;
        logic [dirt_pkg::SLOT_BITS-1:0] slot;
        dirt_pkg::t_entry               ent;
    } t_result;

    localparam int SB = dirt_pkg::SLOT_BITS;
    localparam int UB = dirt_pkg::USED_BITS;

    t_state                r_state, n_state;
    logic [UB-1:0]         r_used,  n_used;
    logic [SB-1:0]         r_ptr,   n_ptr;
    logic [UB-1:0]         r_rem,   n_rem;
    logic                  r_pend,  n_pend;
    logic [SB-1:0]         r_chk,   n_chk;
    logic [SB-1:0]         r_hit,   n_hit;
    logic                  r_found, n_found;
    dirt_pkg::t_entry      r_ent,   n_ent;
    t_req                  r_req,   n_req;
    t_result               r_res,   n_res;
    logic                  r_ovld,  n_ovld;
    t_result               r_out,   n_out;
    logic [UB-1:0]         r_oused, n_oused;

    logic                  wr_en;
    logic [SB-1:0]         wr_addr;
    dirt_pkg::t_entry      wr_data;
    logic [SB-1:0]         rd_addr;
    dirt_pkg::t_entry      rd_data;
    dirt_pkg::t_entry      unit_ent;
    dirt_pkg::t_unit_res   unit;
    dirt_pkg::t_entry      upd_ent;
    dirt_pkg::t_entry      new_ent;
    logic [UB-1:0]         used_m1;
    logic [SB-1:0]         last_slot;
    logic                  table_full;
    logic                  scan_hit;
    dirt_pkg::t_cmd        in_cmd;

    assign in_cmd     = dirt_pkg::t_cmd'(i_cmd.cmd);
    assign used_m1    = r_used - UB'(1);
    assign last_slot  = used_m1[SB-1:0];
    assign table_full = (r_used == UB'(dirt_pkg::ENTRIES));

    // The compare unit looks at memory data while scanning, else at the held hit.
    assign unit_ent = (r_state == S_SCAN) ? rd_data : r_ent;

    dirt_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    dirt_unit u_unit (
        .i_ent (unit_ent),
        .i_idx (r_req.idx),
        .i_len (r_req.len),
        .i_fi  (r_req.fi),
        .o_res (unit)
    );

    assign new_ent = '{base: r_req.idx, count: r_req.len, first_index: r_req.fi,
                       base_vertex: r_req.bv, index_count: r_req.ic};

    always_comb begin
        n_state  = r_state;
        n_used   = r_used;
        n_ptr    = r_ptr;
        n_rem    = r_rem;
        n_pend   = r_pend;
        n_chk    = r_chk;
        n_hit    = r_hit;
        n_found  = r_found;
        n_ent    = r_ent;
        n_req    = r_req;
        n_res    = r_res;
        n_ovld   = r_ovld;
        n_out    = r_out;
        n_oused  = r_oused;
        wr_en    = 1'b0;
        wr_addr  = r_hit;
        wr_data  = r_ent;
        rd_addr  = r_ptr;
        upd_ent  = r_ent;
        scan_hit = 1'b0;

        if (r_ovld && o_res.ready) begin
            n_ovld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_req = '{cmd: in_cmd, idx: i_cmd.instance_index,
                              len: i_cmd.run_length, fi: i_cmd.first_index,
                              bv: i_cmd.base_vertex, ic: i_cmd.index_count};
                    n_pend  = 1'b0;
                    n_found = 1'b0;
                    case (in_cmd)
                        dirt_pkg::CMD_ADD: begin
                            n_ptr   = last_slot;
                            n_rem   = r_used;
                            n_state = S_SCAN;
                        end
                        dirt_pkg::CMD_REMOVE: begin
                            n_ptr   = '0;
                            n_rem   = r_used;
                            n_state = S_SCAN;
                        end
                        dirt_pkg::CMD_READ: begin
                            if (UB'(i_cmd.slot) < r_used) begin
                                n_ptr   = i_cmd.slot;
                                n_state = S_RDWAIT;
                            end else begin
                                n_res   = '{dirt_pkg::ST_NOT_FOUND, i_cmd.slot, '0};
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // One read is issued per cycle; its data is checked in the following cycle.
            S_SCAN: begin
                scan_hit = r_pend && ((r_req.cmd == dirt_pkg::CMD_ADD) ? unit.add_hit
                                                                        : unit.rem_hit);
                if (scan_hit) begin
                    n_ent   = rd_data;
                    n_hit   = r_chk;
                    n_found = 1'b1;
                    n_pend  = 1'b0;
                    n_state = S_ACT;
                end else if (r_rem != '0) begin
                    n_pend = 1'b1;
                    n_chk  = r_ptr;
                    n_rem  = r_rem - UB'(1);
                    n_ptr  = (r_req.cmd == dirt_pkg::CMD_ADD) ? r_ptr - SB'(1)
                                                              : r_ptr + SB'(1);
                end else if (r_req.cmd == dirt_pkg::CMD_ADD) begin
                    n_pend  = 1'b0;
                    n_state = S_ACT;
                end else begin
                    n_pend  = 1'b0;
                    n_res   = '{dirt_pkg::ST_NOT_FOUND, '0, '0};
                    n_state = S_DONE;
                end
            end

            S_ACT: begin
                rd_addr = last_slot;
                n_state = S_DONE;
                if (r_req.cmd == dirt_pkg::CMD_ADD) begin
                    if (r_found && unit.merge_ok) begin
                        upd_ent.count = unit.sum;
                        wr_en   = 1'b1;
                        wr_addr = r_hit;
                        wr_data = upd_ent;
                        n_res   = '{dirt_pkg::ST_MERGED, r_hit, upd_ent};
                    end else if (table_full) begin
                        n_res = '{dirt_pkg::ST_FULL, '0, '0};
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = r_used[SB-1:0];
                        wr_data = new_ent;
                        n_used  = r_used + UB'(1);
                        n_res   = '{dirt_pkg::ST_APPENDED, r_used[SB-1:0], new_ent};
                    end
                end else if (unit.single) begin
                    // The last entry is being read now and moves into the hole.
                    n_state = S_SWAP;
                end else if (unit.top_end) begin
                    upd_ent.count = unit.count_dec;
                    wr_en   = 1'b1;
                    wr_data = upd_ent;
                    n_res   = '{dirt_pkg::ST_TRIMMED, r_hit, upd_ent};
                end else if (unit.low_end) begin
                    upd_ent.base  = unit.base_inc;
                    upd_ent.count = unit.count_dec;
                    wr_en   = 1'b1;
                    wr_data = upd_ent;
                    n_res   = '{dirt_pkg::ST_TRIMMED, r_hit, upd_ent};
                end else if (table_full) begin
                    n_res = '{dirt_pkg::ST_FULL, '0, '0};
                end else begin
                    upd_ent.base  = unit.upper_base;
                    upd_ent.count = unit.upper_count;
                    wr_en   = 1'b1;
                    wr_addr = r_used[SB-1:0];
                    wr_data = upd_ent;
                    n_used  = r_used + UB'(1);
                    n_res   = '{dirt_pkg::ST_SPLIT, r_used[SB-1:0], upd_ent};
                    n_state = S_SPLIT;
                end
            end

            S_SWAP: begin
                wr_en   = 1'b1;
                wr_data = rd_data;
                n_used  = used_m1;
                n_res   = '{dirt_pkg::ST_REMOVED, r_hit, r_ent};
                n_state = S_DONE;
            end

            S_SPLIT: begin
                upd_ent.count = unit.lower_count;
                wr_en   = 1'b1;
                wr_data = upd_ent;
                n_state = S_DONE;
            end

            S_RDWAIT: begin
                n_state = S_RDOUT;
            end

            S_RDOUT: begin
                n_res   = '{dirt_pkg::ST_MERGED, r_ptr, rd_data};
                n_state = S_DONE;
            end

            S_DONE: begin
                if (!r_ovld || o_res.ready) begin
                    n_ovld  = 1'b1;
                    n_out   = r_res;
                    n_oused = r_used;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_pend  <= 1'b0;
            r_found <= 1'b0;
            r_ovld  <= 1'b0;
            r_rem   <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_pend  <= n_pend;
            r_found <= n_found;
            r_ovld  <= n_ovld;
            r_rem   <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr   <= n_ptr;
        r_chk   <= n_chk;
        r_hit   <= n_hit;
        r_ent   <= n_ent;
        r_req   <= n_req;
        r_res   <= n_res;
        r_out   <= n_out;
        r_oused <= n_oused;
    end

    assign i_cmd.ready             = (r_state == S_IDLE);
    assign o_res.valid             = r_ovld;
    assign o_res.status            = r_out.status;
    assign o_res.entry_slot        = r_out.slot;
    assign o_res.entries_used      = r_oused;
    assign o_res.out_base_instance = r_out.ent.base;
    assign o_res.out_run_length    = r_out.ent.count;
    assign o_res.out_first_index   = r_out.ent.first_index;
    assign o_res.out_base_vertex   = r_out.ent.base_vertex;
    assign o_res.out_index_count   = r_out.ent.index_count;

endmodule

// File: src/dirt_chk.sv
module dirt_chk (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  i_in_ready,
    input logic [dirt_pkg::CMD_BITS-1:0]         i_in_cmd,
    input logic                                  i_out_valid,
    input logic                                  i_out_ready,
    input logic [dirt_pkg::STATUS_BITS-1:0]      i_status,
    input logic [dirt_pkg::SLOT_BITS-1:0]        i_entry_slot,
    input logic [dirt_pkg::USED_BITS-1:0]        i_entries_used,
    input logic [dirt_pkg::INST_BITS-1:0]        i_out_base_instance,
    input logic [dirt_pkg::CNT_BITS-1:0]         i_out_run_length,
    input logic [dirt_pkg::WORD_BITS-1:0]        i_out_first_index,
    input logic signed [dirt_pkg::WORD_BITS-1:0] i_out_base_vertex,
    input logic [dirt_pkg::WORD_BITS-1:0]        i_out_index_count
);

    localparam int UB = dirt_pkg::USED_BITS;

    // A real command keeps the block busy for at least the next cycle.
    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_cmd != dirt_pkg::CMD_NOP)) |=> !i_in_ready)
        else $error("command input ready right after a command beat");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable({i_status,
            i_entry_slot, i_entries_used, i_out_base_instance, i_out_run_length,
            i_out_first_index, i_out_base_vertex, i_out_index_count})))
        else $error("stalled result beat changed");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_entries_used <= UB'(dirt_pkg::ENTRIES)))
        else $error("entry count above table size");

    a_new_slot_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && ((i_status == dirt_pkg::ST_APPENDED) ||
                         (i_status == dirt_pkg::ST_SPLIT)))
        |-> ((UB'(i_entry_slot) + UB'(1)) == i_entries_used))
        else $error("new entry not placed at the end of the table");

    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && ((i_status == dirt_pkg::ST_NOT_FOUND) ||
                         (i_status == dirt_pkg::ST_FULL)))
        |-> ((i_out_base_instance == '0) && (i_out_run_length == '0) &&
             (i_out_first_index == '0) && (i_out_base_vertex == '0) &&
             (i_out_index_count == '0)))
        else $error("entry fields not cleared on a miss or full table");

endmodule

bind draw_instance_range_table dirt_chk u_dirt_chk (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_cmd.valid),
    .i_in_ready          (i_cmd.ready),
    .i_in_cmd            (i_cmd.cmd),
    .i_out_valid         (o_res.valid),
    .i_out_ready         (o_res.ready),
    .i_status            (o_res.status),
    .i_entry_slot        (o_res.entry_slot),
    .i_entries_used      (o_res.entries_used),
    .i_out_base_instance (o_res.out_base_instance),
    .i_out_run_length    (o_res.out_run_length),
    .i_out_first_index   (o_res.out_first_index),
    .i_out_base_vertex   (o_res.out_base_vertex),
    .i_out_index_count   (o_res.out_index_count)
);
